FILE: rtl/mei_pkg.sv
// Shared types and constants for the modular exponentiation / inverse unit.
package mei_pkg;
    localparam logic [30:0] MODULUS_RESET = 31'd998244353;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_SQUARE = 6'b000100,
        ST_MULT   = 6'b001000,
        ST_WAIT   = 6'b010000,
        ST_DONE   = 6'b100000
    } mei_state_t;
endpackage

FILE: rtl/modular_exponentiation_inverse_unit.sv
// Top level of the modular exponentiation / Fermat inverse unit.
// Usage: s_ channel carries one request word: tdata = {exponent, base} (base low),
// tuser = req_type (1 = inverse, exponent ignored). m_ channel returns one word per
// request: tdata = result (31 bits, zero padded), tuser = no_inverse.
// cfg_we/cfg_wdata write the modulus; write only while idle. Reset gives 998244353.
// Sequence from input accept to m_axis_tvalid: one base reduction, then per
// exponent bit one square and, for set bits, one multiply, then the result is
// registered for output. Every step is a product on the bit-serial multiplier.
// Inverse: power with exponent modulus - 2; a zero base gives no_inverse.
// Modulus below two: result zero, no_inverse set for an inverse request.
// One request in flight; s_axis_tready stays low from accept until the output word is
// taken, so a new word is accepted at the earliest in the cycle after that.
// A stalled receiver holds the output word and blocks new input.
// Reset clears control state and restores the modulus.
module modular_exponentiation_inverse_unit #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // base[31:0], exponent[63:32]
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result[30:0], zero[31]
    output logic        m_axis_tuser   // no_inverse
);
    import mei_pkg::*;

    logic [MOD_BITS-1:0] mod_reg;
    logic [MOD_BITS-1:0] res;

    always_ff @(posedge aclk) begin
        if (!aresetn) mod_reg <= MODULUS_RESET[MOD_BITS-1:0];
        else if (cfg_we) mod_reg <= cfg_wdata[MOD_BITS-1:0];
    end

    mei_ctrl #(.EXP_BITS(EXP_BITS), .MOD_BITS(MOD_BITS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .req_type(s_axis_tuser), .base(s_axis_tdata[31:0]),
        .exponent(s_axis_tdata[63:32]), .modulus(mod_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .result(res), .no_inverse(m_axis_tuser)
    );

    assign m_axis_tdata = {{(32-MOD_BITS){1'b0}}, res};
endmodule

FILE: rtl/mei_modmul.sv
// Bit-serial modular multiplier: p = a * b mod m, one multiplier bit per cycle, msb first.
module mei_modmul #(
    parameter int MOD_BITS = 31,
    parameter int B_BITS   = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [MOD_BITS-1:0] a,
    input  logic [B_BITS-1:0]   b,
    input  logic [MOD_BITS-1:0] m,
    output logic                busy,
    output logic                done,
    output logic [MOD_BITS-1:0] p
);
    import mei_pkg::*;

    localparam int CW = $clog2(B_BITS + 1);

    logic [MOD_BITS-1:0] acc_reg;
    logic [B_BITS-1:0]   b_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [MOD_BITS+1:0] dbl;
    logic [MOD_BITS+1:0] d1;
    logic [MOD_BITS+1:0] ad;
    logic [MOD_BITS+1:0] acc_next;

    // acc < m, a < m: 2acc-m once, then +a-m once keeps it below m
    always_comb begin
        dbl = {1'b0, acc_reg, 1'b0};
        d1  = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
        ad  = b_reg[B_BITS-1] ? d1 + {2'b00, a} : d1;
        acc_next = (ad >= {2'b00, m}) ? ad - {2'b00, m} : ad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(B_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            b_reg   <= b;
        end else if (busy_reg) begin
            acc_reg <= acc_next[MOD_BITS-1:0];
            b_reg   <= {b_reg[B_BITS-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign p    = acc_reg;
endmodule

FILE: rtl/mei_ctrl.sv
// Square-and-multiply sequencer driving the shared modular multiplier.
module mei_ctrl #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [31:0]         base,
    input  logic [31:0]         exponent,
    input  logic [MOD_BITS-1:0] modulus,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [MOD_BITS-1:0] result,
    output logic                no_inverse
);
    import mei_pkg::*;

    localparam int EU = (EXP_BITS < 32) ? EXP_BITS : 32;
    localparam int EW = (EU > MOD_BITS) ? EU : MOD_BITS;
    localparam int CW = $clog2(EW + 1);

    mei_state_t          state_reg;
    logic [EW-1:0]       exp_reg;
    logic [CW-1:0]       cnt_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [MOD_BITS-1:0] m_reg;
    logic                inv_reg;
    logic [MOD_BITS-1:0] res_reg;
    logic                flag_reg;
    logic                oval_reg;
    logic [31:0]         raw_reg;

    logic                mul_start;
    logic                mul_busy;
    logic                mul_done;
    logic [MOD_BITS-1:0] mul_a;
    logic [31:0]         mul_b;
    logic [MOD_BITS-1:0] mul_p;
    logic                red_reg;

    // reduction of the raw base: 1 * base mod m through the same unit
    always_comb begin
        mul_a = acc_reg;
        mul_b = {{(32-MOD_BITS){1'b0}}, acc_reg};
        if (red_reg) begin
            mul_a = MOD_BITS'(1);
            mul_b = raw_reg;
        end else if (state_reg == ST_MULT) begin
            mul_b = {{(32-MOD_BITS){1'b0}}, b_reg};
        end
    end

    mei_modmul #(.MOD_BITS(MOD_BITS), .B_BITS(32)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .m(m_reg),
        .busy(mul_busy), .done(mul_done), .p(mul_p)
    );

    assign in_ready = (state_reg == ST_IDLE) && !oval_reg;
    logic accept;
    assign accept = in_valid && in_ready;

    // exponent is aligned to its top bit at EW; when EW > used width, pre-shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            oval_reg  <= 1'b0;
            mul_start <= 1'b0;
            red_reg   <= 1'b0;
        end else begin
            mul_start <= 1'b0;
            if (oval_reg && out_ready) oval_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        inv_reg <= req_type;
                        raw_reg <= base;
                        m_reg   <= modulus;
                        exp_reg <= EW'(exponent[EU-1:0]) << (EW - EU);
                        cnt_reg <= CW'(EU);
                        if (modulus < MOD_BITS'(2)) begin
                            res_reg  <= '0;
                            flag_reg <= req_type;
                            state_reg <= ST_DONE;
                        end else begin
                            red_reg   <= 1'b1;
                            mul_start <= 1'b1;
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE: begin
                    if (mul_done) begin
                        red_reg  <= 1'b0;
                        b_reg    <= mul_p;
                        acc_reg  <= MOD_BITS'(1);
                        flag_reg <= 1'b0;
                        if (inv_reg) begin
                            exp_reg <= EW'(m_reg - MOD_BITS'(2)) << (EW - MOD_BITS);
                            cnt_reg <= CW'(MOD_BITS);
                        end
                        if (inv_reg && mul_p == '0) begin
                            res_reg  <= '0;
                            flag_reg <= 1'b1;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    if (cnt_reg == '0) begin
                        res_reg   <= acc_reg;
                        state_reg <= ST_DONE;
                    end else if (!mul_busy) begin
                        mul_start <= 1'b1;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    if (mul_done) begin
                        acc_reg <= mul_p;
                        if (exp_reg[EW-1] && cnt_reg != '0) begin
                            mul_start <= 1'b1;
                            state_reg <= ST_MULT;
                        end else begin
                            exp_reg   <= exp_reg << 1;
                            cnt_reg   <= cnt_reg - 1'b1;
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_MULT: begin
                    if (mul_done) begin
                        acc_reg   <= mul_p;
                        exp_reg   <= exp_reg << 1;
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_DONE: begin
                    if (!oval_reg) begin
                        oval_reg  <= 1'b1;
                        result    <= res_reg;
                        no_inverse <= flag_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = oval_reg;
endmodule

FILE: rtl/mei_checker.sv
// Port-level checker for the modular exponentiation unit, bound to the top level.
module mei_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped");
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("flag with nonzero result");
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while output pending");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while busy");
endmodule

bind modular_exponentiation_inverse_unit mei_checker u_mei_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
